### rtl/core/cpcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_pkg
// shared types, widths and helpers for the circle pair collision resolver
// ----------------------------------------------------------------------------
package cpcr_pkg;

  localparam int unsigned PARTICLE_COUNT_DEF = 1024;
  localparam int unsigned IN_IDX_W    = 10;  // index width on the bus
  localparam int unsigned IDX_W       = 16;  // widest reduced index
  localparam int unsigned POS_W       = 32;
  localparam int unsigned RAD_W       = 24;
  localparam int unsigned MASS_W      = 16;
  localparam int unsigned TDATA_W     = 128;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned SQ_W        = 52;  // squared distance into the root unit
  localparam int unsigned ROOT_W      = 26;  // floor root of a 52 bit value
  localparam int unsigned DEN_W       = 26;  // divisor width
  localparam int unsigned QUO_W       = 32;  // quotient bits, one per step
  localparam int unsigned FAR_BIT     = 25;  // a delta at or above 2^25 never overlaps

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_TEST    = 2'd2,
    REQ_RESOLVE = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t              kind;
    logic                   same;
    logic [IDX_W-1:0]       first_idx;
    logic [IDX_W-1:0]       second_idx;
    logic [POS_W-1:0]       pos_x;
    logic [POS_W-1:0]       pos_y;
    logic [RAD_W-1:0]       radius;
    logic [MASS_W-1:0]      mass;
  } req_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [RAD_W-1:0]  r;
    logic [MASS_W-1:0] m;
  } particle_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_READ,
    BK_SQX,
    BK_SQY,
    BK_SQR,
    BK_CMP,
    BK_ROOT_GO,
    BK_ROOT_WAIT,
    BK_CHECK,
    BK_MULH,
    BK_DIV_GO,
    BK_DIV_WAIT,
    BK_MXI,
    BK_MXJ,
    BK_MYI,
    BK_MYJ,
    BK_WRI,
    BK_WRJ,
    BK_DONE
  } bk_state_t;

  // bus index modulo the table size, restoring style, one bit per step
  function automatic logic [IDX_W-1:0] reduce_index(input logic [IN_IDX_W-1:0] v,
                                                    input logic [IDX_W:0] cnt);
    logic [IDX_W+1:0] rem;
    rem = '0;
    for (int b = IN_IDX_W - 1; b >= 0; b--) begin
      rem = {rem[IDX_W:0], v[b]};
      if (rem >= {1'b0, cnt}) begin
        rem = rem - {1'b0, cnt};
      end
    end
    return rem[IDX_W-1:0];
  endfunction

endpackage

### rtl/core/cpcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_front
// accepts request beats, decodes and reduces indices, queues them for the back
// ----------------------------------------------------------------------------
module cpcr_front #(
  parameter int unsigned PARTICLE_COUNT = cpcr_pkg::PARTICLE_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cpcr_pkg::TDATA_W-1:0]       in_tdata,
  input  logic [1:0]                         in_tuser,
  output logic                               q_valid,
  output cpcr_pkg::req_item_t                q_item,
  input  logic                               q_pop
);
  import cpcr_pkg::*;

  localparam int unsigned QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [IDX_W:0] CNT = PARTICLE_COUNT[IDX_W:0];

  req_item_t        q_mem [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QP_W:0]    cnt_r;
  req_item_t        item_w;
  logic             push;

  always_comb begin
    item_w.kind       = req_kind_t'(in_tuser);
    item_w.first_idx  = reduce_index(in_tdata[9:0], CNT);
    item_w.second_idx = reduce_index(in_tdata[19:10], CNT);
    item_w.same       = (item_w.first_idx == item_w.second_idx);
    item_w.pos_x      = in_tdata[51:20];
    item_w.pos_y      = in_tdata[83:52];
    item_w.radius     = in_tdata[107:84];
    item_w.mass       = in_tdata[123:108];
  end

  assign in_tready = (cnt_r != QUEUE_DEPTH[QP_W:0]);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= item_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
    end
  end

endmodule

### rtl/core/cpcr_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_sqrt
// floor square root, digit by digit, one result bit per cycle
// ----------------------------------------------------------------------------
module cpcr_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cpcr_pkg::SQ_W-1:0]     value,
  output logic                          done,
  output logic [cpcr_pkg::ROOT_W-1:0]   root
);
  import cpcr_pkg::*;

  localparam int unsigned CW = $clog2(ROOT_W);

  logic [SQ_W-1:0]   val_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [ROOT_W+2:0] rem_sh, trial;
  logic              ge;

  always_comb begin
    rem_sh = {rem_r, val_r[SQ_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      val_r <= {val_r[SQ_W-3:0], 2'b00};
      cnt_r <= cnt_r + 1'b1;
      if (ge) begin
        rem_r  <= (ROOT_W+1)'(rem_sh - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(ROOT_W - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(ROOT_W - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/core/cpcr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_div
// restoring divider, one quotient bit per cycle, quotient known below 2^32
// ----------------------------------------------------------------------------
module cpcr_div (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic [cpcr_pkg::DEN_W+cpcr_pkg::QUO_W-1:0] num,
  input  logic [cpcr_pkg::DEN_W-1:0]                 den,
  output logic                                       done,
  output logic [cpcr_pkg::QUO_W-1:0]                 quo
);
  import cpcr_pkg::*;

  localparam int unsigned CW = $clog2(QUO_W);

  logic [QUO_W-1:0] num_r, quo_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r, num_r[QUO_W-1]};
    ge     = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // upper part is already below the divisor
      rem_r <= num[DEN_W+QUO_W-1:QUO_W];
      num_r <= num[QUO_W-1:0];
      den_r <= den;
      quo_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[QUO_W-2:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
      rem_r <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(QUO_W - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(QUO_W - 1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### rtl/core/cpcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpcr_back
// particle table, pair sequencer with shared multiplier, root and divide units
// ----------------------------------------------------------------------------
module cpcr_back #(
  parameter int unsigned PARTICLE_COUNT = cpcr_pkg::PARTICLE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  cpcr_pkg::req_item_t           q_item,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cpcr_pkg::TDATA_W-1:0]  out_tdata,
  output logic                          out_tuser
);
  import cpcr_pkg::*;

  localparam int unsigned AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

  // particle table, one write and two reads a cycle
  particle_t  mem [PARTICLE_COUNT];
  particle_t  rd_i_q, rd_j_q, wr_data;
  logic [AW-1:0] rd_addr_i, rd_addr_j, wr_addr;
  logic       wr_en;

  bk_state_t  state_r, state_nxt;
  req_kind_t  kind_r;
  logic       same_r;
  logic [AW-1:0] i_r, j_r;
  logic [POS_W-1:0]  xi_r, yi_r, xj_r, yj_r;
  logic [RAD_W-1:0]  ri_r, rj_r;
  logic [MASS_W-1:0] mi_r, mj_r;
  logic [FAR_BIT-1:0] adx_r, ady_r;
  logic       dxn_r, dxz_r, dyn_r, dyz_r, far_r, coll_r;
  logic [2*FAR_BIT-1:0] sqx_r, sqy_r, sqr_r;
  logic [2*FAR_BIT:0]   d2_r;
  logic [ROOT_W-1:0]    d_r;
  logic [FAR_BIT-1:0]   h_r;
  logic [FAR_BIT+MASS_W-1:0] hm_r;
  logic [1:0]           sel_r;
  logic [QUO_W-2:0]     nx_r, ny_r;
  logic [QUO_W-1:0]     t1_r, t2_r;
  logic                 out_valid_r, out_user_r;
  logic [TDATA_W-1:0]   out_data_r;

  // combinational datapath
  logic [POS_W:0]     dx_w, dy_w, adx_w, ady_w;
  logic               far_w;
  logic [FAR_BIT:0]   rs_w;
  logic [2*FAR_BIT:0] d2_w;
  logic               coll_w;
  logic [MASS_W:0]    msum_w;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [POS_W-1:0]   s_w;
  logic               sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0]  sq_root;
  logic [DEN_W+QUO_W-1:0] dv_num;
  logic [DEN_W-1:0]   dv_den;
  logic [QUO_W-1:0]   dv_quo;
  logic               out_load;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_i_q <= mem[rd_addr_i];
    rd_j_q <= mem[rd_addr_j];
  end

  assign rd_addr_i = q_item.first_idx[AW-1:0];
  assign rd_addr_j = q_item.second_idx[AW-1:0];

  always_comb begin
    dx_w   = {rd_j_q.x[POS_W-1], rd_j_q.x} - {rd_i_q.x[POS_W-1], rd_i_q.x};
    dy_w   = {rd_j_q.y[POS_W-1], rd_j_q.y} - {rd_i_q.y[POS_W-1], rd_i_q.y};
    adx_w  = dx_w[POS_W] ? (~dx_w + 1'b1) : dx_w;
    ady_w  = dy_w[POS_W] ? (~dy_w + 1'b1) : dy_w;
    far_w  = (|adx_w[POS_W:FAR_BIT]) || (|ady_w[POS_W:FAR_BIT]);
    rs_w   = {1'b0, ri_r} + {1'b0, rj_r};
    d2_w   = {1'b0, sqx_r} + {1'b0, sqy_r};
    msum_w = {1'b0, mi_r} + {1'b0, mj_r};
    if (kind_r == REQ_TEST) begin
      coll_w = !far_r && (d2_w <= {1'b0, sqr_r});
    end else begin
      coll_w = !same_r && !far_r && (d2_w < {1'b0, sqr_r});
    end
  end

  // one shared multiplier, operands picked by state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      BK_SQX: begin mul_a = 32'(adx_r); mul_b = 32'(adx_r); end
      BK_SQY: begin mul_a = 32'(ady_r); mul_b = 32'(ady_r); end
      BK_SQR: begin mul_a = 32'(rs_w);  mul_b = 32'(rs_w);  end
      BK_MULH: begin
        mul_a = 32'(h_r);
        mul_b = 32'((sel_r == 2'd2) ? mj_r : mi_r);
      end
      BK_MXI: begin mul_a = 32'(nx_r); mul_b = t1_r; end
      BK_MXJ: begin mul_a = 32'(nx_r); mul_b = t2_r; end
      BK_MYI: begin mul_a = 32'(ny_r); mul_b = t1_r; end
      BK_MYJ: begin mul_a = 32'(ny_r); mul_b = t2_r; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
    s_w   = 32'(mul_p[63:38]);
  end

  always_comb begin
    if (sel_r[1]) begin
      dv_num = {9'b0, hm_r, 8'b0};
      dv_den = {8'b0, msum_w, 1'b0};
    end else begin
      dv_num = {3'b0, (sel_r[0] ? ady_r : adx_r), 30'b0};
      dv_den = d_r;
    end
  end

  cpcr_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value ({1'b0, d2_r}),
    .done  (sq_done),
    .root  (sq_root)
  );

  cpcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  // next state and control
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = i_r;
    wr_data   = '{x: xi_r, y: yi_r, r: ri_r, m: mi_r};
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == REQ_WRITE) begin
            wr_en     = 1'b1;
            wr_addr   = q_item.first_idx[AW-1:0];
            wr_data   = '{x: q_item.pos_x, y: q_item.pos_y, r: q_item.radius,
                          m: q_item.mass};
            state_nxt = BK_DONE;
          end else begin
            state_nxt = BK_READ;
          end
        end
      end
      BK_READ:      state_nxt = (kind_r == REQ_READ) ? BK_DONE : BK_SQX;
      BK_SQX:       state_nxt = BK_SQY;
      BK_SQY:       state_nxt = BK_SQR;
      BK_SQR:       state_nxt = BK_CMP;
      BK_CMP: begin
        state_nxt = (kind_r == REQ_RESOLVE && coll_w) ? BK_ROOT_GO : BK_DONE;
      end
      BK_ROOT_GO: begin
        sq_start  = 1'b1;
        state_nxt = BK_ROOT_WAIT;
      end
      BK_ROOT_WAIT: if (sq_done) state_nxt = BK_CHECK;
      BK_CHECK: begin
        state_nxt = (d_r == '0 || msum_w == '0) ? BK_DONE : BK_DIV_GO;
      end
      BK_MULH:      state_nxt = BK_DIV_GO;
      BK_DIV_GO: begin
        dv_start  = 1'b1;
        state_nxt = BK_DIV_WAIT;
      end
      BK_DIV_WAIT: begin
        if (dv_done) begin
          if (sel_r == 2'd3) begin
            state_nxt = BK_MXI;
          end else if (sel_r == 2'd0) begin
            state_nxt = BK_DIV_GO;
          end else begin
            state_nxt = BK_MULH;
          end
        end
      end
      BK_MXI:       state_nxt = BK_MXJ;
      BK_MXJ:       state_nxt = BK_MYI;
      BK_MYI:       state_nxt = BK_MYJ;
      BK_MYJ:       state_nxt = BK_WRI;
      BK_WRI: begin
        wr_en     = 1'b1;
        state_nxt = BK_WRJ;
      end
      BK_WRJ: begin
        wr_en     = 1'b1;
        wr_addr   = j_r;
        wr_data   = '{x: xj_r, y: yj_r, r: rj_r, m: mj_r};
        state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default:      state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          kind_r <= q_item.kind;
          same_r <= q_item.same;
          i_r    <= q_item.first_idx[AW-1:0];
          j_r    <= q_item.second_idx[AW-1:0];
          coll_r <= 1'b0;
          sel_r  <= 2'd0;
          xi_r   <= q_item.pos_x;
          yi_r   <= q_item.pos_y;
          xj_r   <= '0;
          yj_r   <= '0;
        end
      end
      BK_READ: begin
        xi_r  <= rd_i_q.x;
        yi_r  <= rd_i_q.y;
        ri_r  <= rd_i_q.r;
        rj_r  <= rd_j_q.r;
        mi_r  <= rd_i_q.m;
        mj_r  <= rd_j_q.m;
        if (kind_r != REQ_READ) begin
          xj_r <= rd_j_q.x;
          yj_r <= rd_j_q.y;
        end
        adx_r <= adx_w[FAR_BIT-1:0];
        ady_r <= ady_w[FAR_BIT-1:0];
        dxn_r <= dx_w[POS_W];
        dyn_r <= dy_w[POS_W];
        dxz_r <= (dx_w == '0);
        dyz_r <= (dy_w == '0);
        far_r <= far_w;
      end
      BK_SQX:  sqx_r <= mul_p[2*FAR_BIT-1:0];
      BK_SQY:  sqy_r <= mul_p[2*FAR_BIT-1:0];
      BK_SQR:  sqr_r <= mul_p[2*FAR_BIT-1:0];
      BK_CMP: begin
        d2_r   <= d2_w;
        coll_r <= coll_w;
      end
      BK_ROOT_WAIT: if (sq_done) d_r <= sq_root;
      BK_CHECK: h_r <= FAR_BIT'(rs_w - {1'b0, d_r[FAR_BIT-1:0]});
      BK_MULH:  hm_r <= mul_p[FAR_BIT+MASS_W-1:0];
      BK_DIV_WAIT: begin
        if (dv_done) begin
          sel_r <= sel_r + 2'd1;
          case (sel_r)
            2'd0:    nx_r <= dv_quo[QUO_W-2:0];
            2'd1:    ny_r <= dv_quo[QUO_W-2:0];
            2'd2:    t1_r <= dv_quo;
            default: t2_r <= dv_quo;
          endcase
        end
      end
      // first particle moves against the delta, the second along it
      BK_MXI: if (!dxz_r) xi_r <= dxn_r ? xi_r + s_w : xi_r - s_w;
      BK_MXJ: if (!dxz_r) xj_r <= dxn_r ? xj_r - s_w : xj_r + s_w;
      BK_MYI: if (!dyz_r) yi_r <= dyn_r ? yi_r + s_w : yi_r - s_w;
      BK_MYJ: if (!dyz_r) yj_r <= dyn_r ? yj_r - s_w : yj_r + s_w;
      default: ;
    endcase
    if (out_load) begin
      out_user_r <= coll_r;
      out_data_r <= {yj_r, xj_r, yi_r, xi_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_wr_pair_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_WRI || state_r == BK_WRJ) |-> (kind_r == REQ_RESOLVE && !same_r))
    else $error("pair write-back outside a resolve");

  a_check_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CHECK) |-> (coll_r && !far_r))
    else $error("root taken for a pair that does not overlap");

  a_root_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == BK_ROOT_WAIT))
    else $error("root finished while not awaited");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == BK_DONE))
    else $error("result raised outside the finish state");

endmodule

### rtl/core/circle_pair_collision_resolver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_pair_collision_resolver_core
// table of 2D circles with write, read, overlap test and mass-weighted push
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata: request fields, tuser: request kind
//  out_    | out | out_tvalid/out_tready| tdata: positions, tuser: overlap flag
//
//  resolve of an overlapping pair runs a 26 step root unit and four 32 step
//  divides on one shared divider
//  reset is synchronous and active low; the particle table is not cleared
//  a two entry request queue lets the input keep taking beats while the back
//  works, and the output register holds a result until the sink takes it
// ----------------------------------------------------------------------------
module circle_pair_collision_resolver_core #(
  parameter int unsigned PARTICLE_COUNT = cpcr_pkg::PARTICLE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // first_index[9:0], second_index[19:10], pos_x[51:20], pos_y[83:52],
  // radius[107:84], mass[123:108], zero pad
  input  logic [cpcr_pkg::TDATA_W-1:0]  in_tdata,
  // req_type[1:0]
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // first_x[31:0], first_y[63:32], second_x[95:64], second_y[127:96]
  output logic [cpcr_pkg::TDATA_W-1:0]  out_tdata,
  // collided[0]
  output logic                          out_tuser
);
  import cpcr_pkg::*;

  // decoded requests between front and back
  logic      q_valid, q_pop;
  req_item_t q_item;

  // front: decode, index reduction, request queue
  cpcr_front #(.PARTICLE_COUNT(PARTICLE_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // back: particle table, pair arithmetic, result register
  cpcr_back #(.PARTICLE_COUNT(PARTICLE_COUNT)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
